// ===== src/glhm_pkg.sv =====
`timescale 1ns / 1ps

package glhm_pkg;

    localparam int LEVELS        = 256;
    localparam int LEVEL_BITS    = $clog2(LEVELS);
    localparam int COUNT_BITS    = 24;
    localparam int PCT_FRAC_BITS = 8;
    localparam int PCT_SCALE     = 100;
    localparam int SCALE_BITS    = $clog2(PCT_SCALE + 1);
    localparam int PROD_BITS     = COUNT_BITS + SCALE_BITS;
    localparam int NUM_BITS      = PROD_BITS + PCT_FRAC_BITS;
    localparam int SHARE_BITS    = 15;
    localparam int QCNT_BITS     = $clog2(SHARE_BITS + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [1:0]            t_op;
    typedef logic [7:0]            t_level;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [SHARE_BITS-1:0] t_share;
    typedef logic [1:0]            t_status;

    localparam t_op OP_ADD   = 2'd0;
    localparam t_op OP_READ  = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_ADD_RANGE = 2'd1;
    localparam t_status ST_RD_RANGE  = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

    localparam t_level MAX_LEVEL_RESET = 8'd255;

endpackage

// ===== src/glhm_in_if.sv =====
`timescale 1ns / 1ps

interface glhm_in_if;
    logic                  valid;
    logic                  ready;
    glhm_pkg::t_op         operation;
    glhm_pkg::t_level      pixel_level;

    modport source (output valid, output operation, output pixel_level, input ready);
    modport sink   (input valid, input operation, input pixel_level, output ready);
endinterface

// ===== src/glhm_out_if.sv =====
`timescale 1ns / 1ps

interface glhm_out_if;
    logic                  valid;
    logic                  ready;
    glhm_pkg::t_level      mode_level;
    glhm_pkg::t_count      mode_count;
    glhm_pkg::t_count      bin_count;
    glhm_pkg::t_count      total_pixels;
    glhm_pkg::t_share      percent_share;
    glhm_pkg::t_status     status;

    modport source (output valid, output mode_level, output mode_count, output bin_count,
                    output total_pixels, output percent_share, output status, input ready);
    modport sink   (input valid, input mode_level, input mode_count, input bin_count,
                    input total_pixels, input percent_share, input status, output ready);
endinterface

// ===== src/glhm_cfg_if.sv =====
`timescale 1ns / 1ps

interface glhm_cfg_if;
    logic                  valid;
    logic                  ready;
    glhm_pkg::t_level      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/grey_level_histogram_with_mode.sv =====
`timescale 1ns / 1ps

// Grey-level histogram with running mode. The 256 bins live in a single-port synchronous
// memory with per-bin valid flags, so a clear takes effect at once. Each item is handled
// on its own: an add, a clear or a rejected read is a memory read, then an update and
// write back, while a valid read also runs the bit-serial divider, which forms the
// percentage one quotient bit per cycle. A new item is accepted while the previous
// result still waits in the output register.

module grey_level_histogram_with_mode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    glhm_in_if.sink        i_in,
    glhm_cfg_if.sink       i_cfg,
    glhm_out_if.source     o_out
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_START = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    glhm_pkg::t_count                 mem [glhm_pkg::LEVELS];
    logic [glhm_pkg::LEVELS-1:0]      r_valid;
    glhm_pkg::t_count                 r_rdata;

    logic [1:0]                       r_state;
    logic [1:0]                       n_state;
    glhm_pkg::t_op                    r_op;
    glhm_pkg::t_level                 r_lvl;
    glhm_pkg::t_level                 r_max_level;
    glhm_pkg::t_count                 r_total;
    glhm_pkg::t_count                 n_total;
    glhm_pkg::t_level                 r_best_level;
    glhm_pkg::t_level                 n_best_level;
    glhm_pkg::t_count                 r_best_count;
    glhm_pkg::t_count                 n_best_count;
    glhm_pkg::t_count                 r_rd_count;
    logic [glhm_pkg::NUM_BITS-1:0]    r_num;

    logic                             r_out_valid;
    glhm_pkg::t_level                 r_out_mode_level;
    glhm_pkg::t_count                 r_out_mode_count;
    glhm_pkg::t_count                 r_out_bin_count;
    glhm_pkg::t_count                 r_out_total;
    glhm_pkg::t_share                 r_out_share;
    glhm_pkg::t_status                r_out_status;

    logic                             in_acc;
    logic                             out_free;
    logic                             lvl_ok;
    glhm_pkg::t_count                 cur_count;
    glhm_pkg::t_count                 n_count;
    logic [glhm_pkg::PROD_BITS-1:0]   n_prod;
    logic                             mem_we;
    logic                             clr_all;
    logic                             out_we;
    glhm_pkg::t_count                 n_out_bin;
    glhm_pkg::t_share                 n_out_share;
    glhm_pkg::t_status                n_out_status;
    logic                             div_start;
    logic                             div_busy;
    glhm_pkg::t_share                 div_quot;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    always_comb begin
        lvl_ok    = (r_lvl <= r_max_level) &&
                    ({1'b0, r_lvl} < 9'(glhm_pkg::LEVELS));
        cur_count = r_valid[r_lvl[glhm_pkg::LEVEL_BITS-1:0]] ? r_rdata : '0;
        n_count   = (cur_count == glhm_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;
        n_prod    = glhm_pkg::PROD_BITS'(cur_count) *
                    glhm_pkg::PROD_BITS'(glhm_pkg::PCT_SCALE);

        n_state      = r_state;
        n_total      = r_total;
        n_best_level = r_best_level;
        n_best_count = r_best_count;
        mem_we       = 1'b0;
        clr_all      = 1'b0;
        out_we       = 1'b0;
        div_start    = 1'b0;
        n_out_bin    = '0;
        n_out_share  = '0;
        n_out_status = glhm_pkg::ST_OK;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    glhm_pkg::OP_ADD: begin
                        if (out_free) begin
                            out_we  = 1'b1;
                            n_state = S_IDLE;
                            if (!lvl_ok) begin
                                n_out_status = glhm_pkg::ST_ADD_RANGE;
                            end else begin
                                mem_we = 1'b1;
                                if (r_total != glhm_pkg::COUNT_MAX) begin
                                    n_total = r_total + 1'b1;
                                end
                                if ((n_count > r_best_count) ||
                                    ((n_count == r_best_count) && (r_lvl < r_best_level))) begin
                                    n_best_count = n_count;
                                    n_best_level = r_lvl;
                                end
                            end
                        end
                    end
                    glhm_pkg::OP_READ: begin
                        if (lvl_ok && (r_total != '0)) begin
                            n_state = S_START;
                        end else if (out_free) begin
                            out_we       = 1'b1;
                            n_state      = S_IDLE;
                            n_out_status = lvl_ok ? glhm_pkg::ST_EMPTY
                                                  : glhm_pkg::ST_RD_RANGE;
                        end
                    end
                    glhm_pkg::OP_CLEAR: begin
                        if (out_free) begin
                            out_we       = 1'b1;
                            clr_all      = 1'b1;
                            n_state      = S_IDLE;
                            n_total      = '0;
                            n_best_level = '0;
                            n_best_count = '0;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            out_we  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_START: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (!div_busy && out_free) begin
                    out_we      = 1'b1;
                    n_state     = S_IDLE;
                    n_out_bin   = r_rd_count;
                    n_out_share = div_quot;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rdata <= mem[i_in.pixel_level[glhm_pkg::LEVEL_BITS-1:0]];
        end
        if (mem_we) begin
            mem[r_lvl[glhm_pkg::LEVEL_BITS-1:0]] <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_max_level  <= glhm_pkg::MAX_LEVEL_RESET;
            r_total      <= '0;
            r_best_level <= '0;
            r_best_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_best_level <= n_best_level;
            r_best_count <= n_best_count;
            if (clr_all) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[r_lvl[glhm_pkg::LEVEL_BITS-1:0]] <= 1'b1;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_level <= i_cfg.data;
            end
            if (out_we) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_in.operation;
            r_lvl <= i_in.pixel_level;
        end
        if (r_state == S_EXEC) begin
            r_rd_count <= cur_count;
            r_num      <= glhm_pkg::NUM_BITS'(n_prod) << glhm_pkg::PCT_FRAC_BITS;
        end
        if (out_we) begin
            r_out_mode_level <= n_best_level;
            r_out_mode_count <= n_best_count;
            r_out_bin_count  <= n_out_bin;
            r_out_total      <= n_total;
            r_out_share      <= n_out_share;
            r_out_status     <= n_out_status;
        end
    end

    glhm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_total),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.mode_level    = r_out_mode_level;
    assign o_out.mode_count    = r_out_mode_count;
    assign o_out.bin_count     = r_out_bin_count;
    assign o_out.total_pixels  = r_out_total;
    assign o_out.percent_share = r_out_share;
    assign o_out.status        = r_out_status;

endmodule

// ===== src/glhm_div.sv =====
`timescale 1ns / 1ps

module glhm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [glhm_pkg::NUM_BITS-1:0]       i_num,
    input  glhm_pkg::t_count                    i_den,
    output logic                                o_busy,
    output glhm_pkg::t_share                    o_quot
);

    logic                                r_busy;
    logic [glhm_pkg::QCNT_BITS-1:0]      r_cnt;
    glhm_pkg::t_count                    r_rem;
    glhm_pkg::t_count                    r_den;
    glhm_pkg::t_share                    r_low;
    logic [glhm_pkg::COUNT_BITS:0]       n_trial;
    logic                                n_fits;

    always_comb begin
        n_trial = {r_rem, r_low[glhm_pkg::SHARE_BITS-1]};
        n_fits  = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= glhm_pkg::QCNT_BITS'(glhm_pkg::SHARE_BITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == glhm_pkg::QCNT_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= glhm_pkg::COUNT_BITS'(i_num >> glhm_pkg::SHARE_BITS);
            r_low <= glhm_pkg::SHARE_BITS'(i_num);
            r_den <= i_den;
        end else if (r_busy) begin
            if (n_fits) begin
                r_rem <= glhm_pkg::COUNT_BITS'(n_trial - {1'b0, r_den});
            end else begin
                r_rem <= glhm_pkg::COUNT_BITS'(n_trial);
            end
            r_low <= {r_low[glhm_pkg::SHARE_BITS-2:0], n_fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_low;

endmodule
